### rtl/asfc_pkg.sv
package asfc_pkg;

    // Default number of fraction bits in the incoming fixed-point sample
    localparam int FRACTION_BITS_DEF = 8;

    localparam int SAMPLE_W = 48;
    localparam int CODE_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int MODE_W   = 3;

    // Output format codes
    localparam logic [MODE_W-1:0] MODE_SHORT16 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCHAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OFFSET8 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MULAW   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LONG32  = 3'd4;

    // Saturation bounds and mu-law constants
    localparam logic [15:0] S16_MAX     = 16'h7FFF;
    localparam logic [15:0] S16_MIN     = 16'h8000;
    localparam logic [15:0] S16_NEG_LIM = 16'd32768;
    localparam logic [31:0] L32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] L32_MIN     = 32'h8000_0001;
    localparam logic [14:0] MU_CLIP     = 15'd32635;
    localparam logic [15:0] MU_BIAS     = 16'h0084;
    localparam logic [7:0]  MU_ZERO     = 8'h02;
    localparam logic [7:0]  OFFSET_FLIP = 8'h80;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_in_block;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0]  coded_word;
        logic               was_clipped;
        logic [COUNT_W-1:0] clip_total;
        logic               block_end;
    } t_out;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              clip;
    } t_enc_res;

endpackage

### rtl/audio_sample_format_converter.sv
// Audio sample format converter.
// Input channel (i_in_valid / o_in_ready / i_in_data): one signed fixed-point
// sample per transfer, with a flag for the last sample of a buffer.
// Output channel (o_out_valid / i_out_ready / o_out_data): one coded word per
// input, with a clip flag, the running clip count and the end-of-buffer flag.
// Configuration: i_cfg_we writes i_cfg_wdata into the format register in the
// same edge; change it only while no sample is in flight.
// Path: input register, one pass of conversion logic, result register that
// drives the output. Throughput: one sample per cycle, sustained while
// i_out_ready is high, set by those two registers around the single pass.
// The input stage keeps taking samples while a result waits, as long as the
// result stage is able to move on in the same cycle.
// Stall: when the receiver holds i_out_ready low, the result holds, the input
// register fills and then o_in_ready drops; nothing is lost or repeated.
// Reset (synchronous, active low): both stages empty, format short16,
// clip count zero.
module audio_sample_format_converter #(
    parameter int FRACTION_BITS = asfc_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [asfc_pkg::MODE_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  asfc_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output asfc_pkg::t_out              o_out_data
);

    logic                         r_in_valid;
    asfc_pkg::t_in                r_in;
    logic                         r_out_valid;
    asfc_pkg::t_out               r_out;
    logic [asfc_pkg::MODE_W-1:0]  r_mode;
    logic [asfc_pkg::COUNT_W-1:0] r_clip_cnt;
    logic [asfc_pkg::COUNT_W-1:0] n_clip_cnt;

    asfc_pkg::t_enc_res enc;
    logic               advance;
    logic               take;

    // Advance the held sample into the result stage when that stage is free
    // or being emptied this cycle; take a new sample when the input stage
    // is free or advancing.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;
    assign o_in_ready = !r_in_valid || advance;

    asfc_encode #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_encode (
        .i_sample (r_in.sample_value),
        .i_mode   (r_mode),
        .o_res    (enc)
    );

    // Saturating clip count, bumped only as a sample moves to the result stage
    always_comb begin
        n_clip_cnt = r_clip_cnt;
        if (advance && enc.clip && (r_clip_cnt != '1)) begin
            n_clip_cnt = r_clip_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= asfc_pkg::MODE_SHORT16;
            r_clip_cnt  <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_clip_cnt <= n_clip_cnt;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.coded_word  <= enc.code;
            r_out.was_clipped <= enc.clip;
            r_out.clip_total  <= n_clip_cnt;
            r_out.block_end   <= r_in.last_in_block;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/asfc_encode.sv
module asfc_encode #(
    parameter int FRACTION_BITS = asfc_pkg::FRACTION_BITS_DEF
) (
    input  logic signed [asfc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [asfc_pkg::MODE_W-1:0]          i_mode,
    output asfc_pkg::t_enc_res                   o_res
);

    logic                          neg;
    logic [asfc_pkg::SAMPLE_W-1:0] mag;
    logic [asfc_pkg::SAMPLE_W-1:0] tmag;
    logic                          s_neg;

    logic        clip16;
    logic [15:0] c16;
    logic        clip32;
    logic [31:0] c32;

    logic        clipmu;
    logic [14:0] mmag;
    logic [15:0] biased;
    logic [6:0]  top;
    logic [2:0]  expo;
    logic [15:0] shifted;
    logic [3:0]  mant;
    logic [7:0]  mu;

    // Truncate toward zero on the magnitude
    assign neg   = i_sample[asfc_pkg::SAMPLE_W-1];
    assign mag   = neg ? (~i_sample + 1'b1) : i_sample;
    assign tmag  = mag >> FRACTION_BITS;
    assign s_neg = neg && (tmag != '0);

    // 16-bit saturation
    always_comb begin
        if (s_neg) begin
            clip16 = (|tmag[47:16]) || (tmag[15:0] > asfc_pkg::S16_NEG_LIM);
            c16    = clip16 ? asfc_pkg::S16_MIN : (~tmag[15:0] + 1'b1);
        end else begin
            clip16 = (|tmag[47:15]);
            c16    = clip16 ? asfc_pkg::S16_MAX : tmag[15:0];
        end
    end

    // 32-bit symmetric saturation
    always_comb begin
        clip32 = |tmag[47:31];
        if (s_neg) begin
            c32 = clip32 ? asfc_pkg::L32_MIN : (~tmag[31:0] + 1'b1);
        end else begin
            c32 = clip32 ? asfc_pkg::L32_MAX : tmag[31:0];
        end
    end

    // Mu-law: clip, bias, exponent from the leading bit, 4-bit mantissa
    always_comb begin
        clipmu  = (|tmag[47:15]) || (tmag[14:0] > asfc_pkg::MU_CLIP);
        mmag    = clipmu ? asfc_pkg::MU_CLIP : tmag[14:0];
        biased  = {1'b0, mmag} + asfc_pkg::MU_BIAS;
        top     = biased[14:8];
        expo    = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (top[i]) begin
                expo = 3'(i + 1);
            end
        end
        shifted = biased >> ({1'b0, expo} + 4'd3);
        mant    = shifted[3:0];
        mu      = ~{s_neg, expo, mant};
        if (mu == 8'h00) begin
            mu = asfc_pkg::MU_ZERO;
        end
    end

    always_comb begin
        case (i_mode)
            asfc_pkg::MODE_SHORT16: begin
                o_res.code = {16'h0000, c16};
                o_res.clip = clip16;
            end
            asfc_pkg::MODE_SCHAR: begin
                o_res.code = {24'h000000, c16[15:8]};
                o_res.clip = clip16;
            end
            asfc_pkg::MODE_OFFSET8: begin
                o_res.code = {24'h000000, c16[15:8] ^ asfc_pkg::OFFSET_FLIP};
                o_res.clip = clip16;
            end
            asfc_pkg::MODE_MULAW: begin
                o_res.code = {24'h000000, mu};
                o_res.clip = clipmu;
            end
            asfc_pkg::MODE_LONG32: begin
                o_res.code = c32;
                o_res.clip = clip32;
            end
            default: begin
                o_res.code = '0;
                o_res.clip = 1'b0;
            end
        endcase
    end

endmodule
